/* design/mss_pkg.sv */
// Package for the motor step-response sequencer: payload structs, event codes,
// drive table and sizing constants. No dependencies.
package mss_pkg;
  localparam int PHASE_COUNT = 14;
  localparam int RING_DEPTH = 5;
  localparam int RING_AW = $clog2(RING_DEPTH + 1);

  typedef enum logic [2:0] {
    EV_NONE = 3'd0, EV_START = 3'd1, EV_PHASE = 3'd2, EV_RESULT = 3'd3,
    EV_DONE = 3'd4, EV_ABORT_STOP = 3'd5, EV_ABORT_STALE = 3'd6, EV_ABORT_INT = 3'd7
  } event_t;

  localparam logic [1:0] FUNC_RUN = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_STOP = 2'd2;
  // spare code, behaves as run
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  localparam logic [1:0] REG_ACTIVE = 2'd0;
  localparam logic [1:0] REG_SETTLE = 2'd1;
  localparam logic [1:0] REG_STALE = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic [31:0] now_ms;
    logic [31:0] packet_count;
    logic [31:0] packet_time_ms;
    logic signed [31:0] left_total;
    logic signed [31:0] right_total;
    logic signed [15:0] left_delta;
    logic signed [15:0] right_delta;
  } in_word_t;

  typedef struct packed {
    logic last;
    logic [2:0] event_res;
    logic [3:0] phase_number;
    logic [6:0] left_drive;
    logic [6:0] right_drive;
    logic wheel;
    logic [15:0] sample_total;
    logic signed [31:0] driven_counts;
    logic signed [15:0] steady_mean;
    logic signed [31:0] coast_counts;
    logic signed [31:0] first_move_ms;
  } out_word_t;

  // Mean unit request/response.
  typedef struct packed {
    logic start;
    logic signed [18:0] sum;
    logic [RING_AW-1:0] count;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic signed [15:0] quot;
  } div_rsp_t;

  function automatic logic [13:0] drive_rom(input logic [3:0] p);
    logic [13:0] r;
    begin
      case (p)
        4'd0: r = {7'd85, 7'd85};
        4'd1: r = {7'd90, 7'd90};
        4'd2: r = {7'd95, 7'd95};
        4'd3: r = {7'd97, 7'd97};
        4'd4: r = {7'd99, 7'd99};
        4'd5: r = {7'd100, 7'd100};
        4'd6: r = {7'd90, 7'd110};
        4'd7: r = {7'd110, 7'd90};
        4'd8: r = {7'd95, 7'd110};
        4'd9: r = {7'd110, 7'd95};
        4'd10: r = {7'd90, 7'd120};
        4'd11: r = {7'd120, 7'd90};
        4'd12: r = {7'd95, 7'd120};
        4'd13: r = {7'd120, 7'd95};
        default: r = 14'd0;
      endcase
      return r;
    end
  endfunction
endpackage

/* design/motor_step_response_sequencer_core.sv */
// Top level of the motor step-response sequencer: tick decoder, ring buffers,
// result sequencer and output register. Depends on mss_pkg and mss_div.
//
//  channel | signals                        | direction
//  input   | in_valid, in_ready, in_data    | one control tick word in
//  output  | out_valid, out_ready, out_data | one or three result words out
//  config  | cfg_valid, cfg_ready, cfg_*    | register writes
//
// A tick that gives a single word is taken and decoded, and its word is registered
// to the output. A phase result tick is held; per wheel, the sequencer adds each
// filled ring entry, closes the sum, runs the serial divider (skipped with an empty
// ring) and emits the result word; the final word follows the second wheel.
// Reset is synchronous; the ring buffers are not cleared, only their fill.
// The input is not ready while a tick is in work or its words are not taken;
// an output stall holds the word and the sequencer.
module motor_step_response_sequencer_core (
  input logic clk,
  input logic rst,
  input logic in_valid,
  output logic in_ready,
  input mss_pkg::in_word_t in_data,
  output logic out_valid,
  input logic out_ready,
  output mss_pkg::out_word_t out_data,
  input logic cfg_valid,
  output logic cfg_ready,
  input logic [1:0] cfg_index,
  input logic [15:0] cfg_data
);
  import mss_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_SUM = 6'b000010, S_DIV = 6'b000100,
    S_EMIT = 6'b001000, S_WAIT = 6'b010000, S_TAIL = 6'b100000
  } seq_t;

  localparam logic [1:0] M_IDLE = 2'd0, M_PRE = 2'd1, M_ACTIVE = 2'd2, M_POST = 2'd3;

  seq_t st;
  logic [15:0] active_time, settle_time, stale_limit;
  logic [1:0] mode;
  logic [31:0] mode_start;
  logic [3:0] phase_pos;
  logic [31:0] start_tot [2];
  logic [31:0] end_tot [2];
  logic [31:0] seen_pc;
  logic [15:0] samples;
  logic [15:0] ring [2][RING_DEPTH];
  logic [RING_AW-1:0] ring_fill, ring_nxt;
  logic [31:0] first_move [2];

  in_word_t t;
  logic w;  // wheel being summed/emitted
  logic [RING_AW-1:0] idx;
  logic signed [18:0] acc;
  logic [31:0] elapsed, age;
  logic fresh;
  div_req_t dreq;
  div_rsp_t drsp;
  logic [13:0] drv_cur, drv_nxt;
  logic [3:0] nxt_pos;
  logic more;

  mss_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign cfg_ready = 1'b1;
  assign in_ready = (st == S_IDLE) && !out_valid;
  assign age = in_data.now_ms - in_data.packet_time_ms;
  assign fresh = (in_data.packet_count != 32'd0) && (age <= {16'd0, stale_limit});
  assign elapsed = in_data.now_ms - mode_start;
  assign drv_cur = drive_rom(phase_pos);
  assign nxt_pos = phase_pos + 4'd1;
  assign more = {1'b0, nxt_pos} < 5'(PHASE_COUNT) && phase_pos != 4'hF;
  assign drv_nxt = drive_rom(nxt_pos);

  always_comb begin
    dreq.start = (st == S_SUM) && (idx == ring_fill) && (ring_fill != '0);
    dreq.sum = acc;
    dreq.count = ring_fill;
  end

  function automatic out_word_t mk(input logic [2:0] ev, input logic [3:0] ph,
                                   input logic [13:0] d);
    out_word_t o;
    begin
      o = '0;
      o.event_res = ev;
      o.phase_number = ph;
      o.left_drive = d[13:7];
      o.right_drive = d[6:0];
      return o;
    end
  endfunction

  always_ff @(posedge clk) begin
    out_word_t ow;
    logic emit;
    ow = '0;
    emit = 1'b0;
    if (rst) begin
      active_time <= 16'd500;
      settle_time <= 16'd800;
      stale_limit <= 16'd200;
      st <= S_IDLE;
      mode <= M_IDLE;
      mode_start <= '0;
      phase_pos <= '0;
      start_tot[0] <= '0; start_tot[1] <= '0;
      end_tot[0] <= '0; end_tot[1] <= '0;
      seen_pc <= '0;
      samples <= '0;
      ring_fill <= '0;
      ring_nxt <= '0;
      first_move[0] <= '1; first_move[1] <= '1;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_ACTIVE: active_time <= cfg_data;
          REG_SETTLE: settle_time <= cfg_data;
          REG_STALE: stale_limit <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) out_valid <= 1'b0;

      case (st)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            ow = mk(EV_NONE, 4'd0, 14'd0);
            ow.last = 1'b1;
            emit = 1'b1;
            if (in_data.func == FUNC_STOP) begin
              ow.event_res = (mode != M_IDLE) ? EV_ABORT_STOP : EV_NONE;
              mode <= M_IDLE;
            end else if (in_data.func == FUNC_START) begin
              if (mode != M_IDLE) begin
              end else if (!fresh) begin
                ow.event_res = EV_ABORT_STALE;
              end else begin
                phase_pos <= '0;
                mode_start <= in_data.now_ms;
                mode <= M_PRE;
                ow.event_res = EV_START;
              end
            end else if (mode == M_IDLE) begin
            end else if (!fresh) begin
              mode <= M_IDLE;
              ow.event_res = EV_ABORT_STALE;
            end else if (mode == M_PRE) begin
              if (elapsed >= {16'd0, settle_time}) begin
                ow = mk(EV_PHASE, phase_pos + 4'd1, drv_cur);
                ow.last = 1'b1;
                start_tot[0] <= in_data.left_total;
                start_tot[1] <= in_data.right_total;
                seen_pc <= in_data.packet_count;
                samples <= '0; ring_fill <= '0; ring_nxt <= '0;
                first_move[0] <= '1; first_move[1] <= '1;
                mode_start <= in_data.now_ms;
                mode <= M_ACTIVE;
              end
            end else if (mode == M_ACTIVE) begin
              if (in_data.packet_count != seen_pc) begin
                seen_pc <= in_data.packet_count;
                if (samples != 16'hFFFF) samples <= samples + 16'd1;
                ring[0][ring_nxt[RING_AW-1:0]] <= in_data.left_delta;
                ring[1][ring_nxt[RING_AW-1:0]] <= in_data.right_delta;
                if (first_move[0][31] && in_data.left_delta != 16'sd0)
                  first_move[0] <= elapsed[31] ? 32'h7FFFFFFF : elapsed;
                if (first_move[1][31] && in_data.right_delta != 16'sd0)
                  first_move[1] <= elapsed[31] ? 32'h7FFFFFFF : elapsed;
                ring_nxt <= (ring_nxt == RING_AW'(RING_DEPTH - 1)) ? '0 : ring_nxt + 1'b1;
                if (ring_fill != RING_AW'(RING_DEPTH)) ring_fill <= ring_fill + 1'b1;
              end
              if (elapsed >= {16'd0, active_time}) begin
                end_tot[0] <= in_data.left_total;
                end_tot[1] <= in_data.right_total;
                mode_start <= in_data.now_ms;
                mode <= M_POST;
              end else begin
                ow = mk(EV_NONE, 4'd0, drv_cur);
                ow.last = 1'b1;
              end
            end else if (elapsed >= {16'd0, settle_time}) begin
              // phase result: hold the tick, sum each ring, then emit three words
              emit = 1'b0;
              t <= in_data;
              w <= 1'b0;
              idx <= '0;
              acc <= '0;
              st <= S_SUM;
            end
            if (emit) begin
              out_valid <= 1'b1;
              out_data <= ow;
            end
          end
        end
        S_SUM: begin
          // advance one ring entry per cycle
          if (idx == ring_fill) begin
            st <= (ring_fill == '0) ? S_EMIT : S_DIV;
          end else begin
            acc <= acc + 19'(signed'(ring[w][idx]));
            idx <= idx + 1'b1;
          end
        end
        S_DIV: if (drsp.done) st <= S_EMIT;
        S_EMIT: begin
          ow = mk(EV_RESULT, phase_pos + 4'd1, more ? drv_nxt : 14'd0);
          ow.last = 1'b0;
          ow.wheel = w;
          ow.sample_total = samples;
          ow.driven_counts = end_tot[w] - start_tot[w];
          ow.steady_mean = (ring_fill == '0) ? 16'sd0 : drsp.quot;
          ow.coast_counts = (w ? t.right_total : t.left_total) - end_tot[w];
          ow.first_move_ms = first_move[w];
          out_valid <= 1'b1;
          out_data <= ow;
          st <= S_WAIT;
        end
        S_WAIT: begin
          if (out_ready) begin
            if (!w) begin
              w <= 1'b1; idx <= '0; acc <= '0;
              st <= S_SUM;
            end else begin
              st <= S_TAIL;
            end
          end
        end
        S_TAIL: begin
          // final word, then commit next phase or finish
          ow = more ? mk(EV_PHASE, nxt_pos + 4'd1, drv_nxt) : mk(EV_DONE, 4'd0, 14'd0);
          ow.last = 1'b1;
          out_valid <= 1'b1;
          out_data <= ow;
          phase_pos <= nxt_pos;
          if (more) begin
            start_tot[0] <= t.left_total;
            start_tot[1] <= t.right_total;
            seen_pc <= t.packet_count;
            samples <= '0; ring_fill <= '0; ring_nxt <= '0;
            first_move[0] <= '1; first_move[1] <= '1;
            mode_start <= t.now_ms;
            mode <= M_ACTIVE;
          end else begin
            mode <= M_IDLE;
          end
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

/* design/mss_div.sv */
// Serial signed divider (restoring, one quotient bit per cycle) for ring means.
// Depends on mss_pkg.
module mss_div (
  input logic clk,
  input logic rst,
  input mss_pkg::div_req_t req,
  output mss_pkg::div_rsp_t rsp
);
  import mss_pkg::*;

  logic [18:0] rem_q, quo_q;
  logic [18:0] rem_sh;
  logic [RING_AW-1:0] den;
  logic neg;
  logic [4:0] cnt;
  logic busy;
  logic done;

  assign rem_sh = {rem_q[17:0], quo_q[18]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 5'd19;
        neg <= req.sum[18];
        quo_q <= req.sum[18] ? 19'(-req.sum) : 19'(req.sum);
        rem_q <= '0;
        den <= req.count;
      end else if (busy) begin
        // shift one dividend bit in, subtract when it fits
        if (rem_sh >= 19'(den)) begin
          rem_q <= rem_sh - 19'(den);
          quo_q <= {quo_q[17:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[17:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = neg ? 16'(-quo_q) : quo_q[15:0];
endmodule

/* design/mss_checker.sv */
// Port-level checker for the sequencer, bound to the top level.
// Depends on mss_pkg.
module mss_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input mss_pkg::out_word_t out_data
);
  import mss_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed under stall");
  a_noaccept: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while output pending");
  a_result_mid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.event_res == EV_RESULT |-> !out_data.last)
    else $error("result word marked last");
  a_notlast: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last |=> !in_ready)
    else $error("input ready before tick finished");
endmodule

bind motor_step_response_sequencer_core mss_checker u_chk (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

/* tb/sv/testbench.sv */
// Self-checking testbench for motor_step_response_sequencer_core: drives control
// tick words, predicts result words in a behavioral model, checks each output word.
// Depends on mss_pkg and the core RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mss_pkg::*;

  typedef enum logic [1:0] {
    MD_IDLE = 2'd0, MD_PRE = 2'd1, MD_ACTIVE = 2'd2, MD_POST = 2'd3
  } seq_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  motor_step_response_sequencer_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: a mirror of the sequencer's registers.
  logic [15:0] act_ms, settle_ms, stale_ms;
  seq_mode_t seq_mode;
  logic [31:0] mode_t0;
  logic [3:0] phase_idx;
  logic [31:0] drv_start [2];
  logic [31:0] drv_end [2];
  logic [31:0] seen_pkt;
  logic [15:0] sample_cnt;
  logic signed [15:0] lring [RING_DEPTH];
  logic signed [15:0] rring [RING_DEPTH];
  int ring_cnt, ring_wr;
  logic [31:0] move_ms [2];

  in_word_t tick_q[$];
  out_word_t expected_words[$];
  int idle_pct = 0, stall_pct = 0;
  int errors = 0;
  longint cycles = 0;
  logic stim_done = 1'b0;

  function automatic out_word_t plain_word(event_t ev, logic [3:0] ph, logic [13:0] drv);
    out_word_t w;
    w = '0;
    w.event_res = ev;
    w.phase_number = ph;
    w.left_drive = drv[13:7];
    w.right_drive = drv[6:0];
    return w;
  endfunction

  function automatic logic signed [15:0] ring_avg(bit right);
    int acc;
    if (ring_cnt == 0) return 0;
    acc = 0;
    for (int i = 0; i < ring_cnt; i++) acc += right ? int'(rring[i]) : int'(lring[i]);
    return 16'(acc / ring_cnt);
  endfunction

  function automatic void arm_phase(in_word_t t);
    drv_start[0] = t.left_total;
    drv_start[1] = t.right_total;
    seen_pkt = t.packet_count;
    sample_cnt = 0;
    ring_cnt = 0;
    ring_wr = 0;
    move_ms[0] = '1;
    move_ms[1] = '1;
    mode_t0 = t.now_ms;
    seq_mode = MD_ACTIVE;
  endfunction

  function automatic void reset_model();
    act_ms = 500; settle_ms = 800; stale_ms = 200;
    seq_mode = MD_IDLE; mode_t0 = 0; phase_idx = 0;
    drv_start[0] = 0; drv_start[1] = 0; drv_end[0] = 0; drv_end[1] = 0;
    seen_pkt = 0; sample_cnt = 0; ring_cnt = 0; ring_wr = 0;
    move_ms[0] = '1; move_ms[1] = '1;
  endfunction

  // Work out the result words of one accepted tick and queue them.
  function automatic void predict_tick(in_word_t t);
    out_word_t w [3];
    int n;
    logic fresh;
    logic [31:0] el, dt;
    logic [3:0] p, nxt;
    logic [13:0] nd;
    n = 1;
    fresh = (t.packet_count != 0) && ((t.now_ms - t.packet_time_ms) <= {16'd0, stale_ms});
    el = t.now_ms - mode_t0;
    p = phase_idx;
    if (t.func == FUNC_STOP) begin
      w[0] = plain_word(seq_mode != MD_IDLE ? EV_ABORT_STOP : EV_NONE, 0, 0);
      seq_mode = MD_IDLE;
    end else if (t.func == FUNC_START) begin
      if (seq_mode != MD_IDLE) w[0] = plain_word(EV_NONE, 0, 0);
      else if (!fresh) w[0] = plain_word(EV_ABORT_STALE, 0, 0);
      else begin
        phase_idx = 0; mode_t0 = t.now_ms; seq_mode = MD_PRE;
        w[0] = plain_word(EV_START, 0, 0);
      end
    end else if (seq_mode == MD_IDLE) begin
      w[0] = plain_word(EV_NONE, 0, 0);
    end else if (!fresh) begin
      seq_mode = MD_IDLE;
      w[0] = plain_word(EV_ABORT_STALE, 0, 0);
    end else if (seq_mode == MD_PRE) begin
      if (el >= settle_ms) begin
        arm_phase(t);
        w[0] = plain_word(EV_PHASE, p + 4'd1, drive_rom(p));
      end else w[0] = plain_word(EV_NONE, 0, 0);
    end else if (seq_mode == MD_ACTIVE) begin
      if (t.packet_count != seen_pkt) begin
        dt = el[31] ? 32'h7FFF_FFFF : el;
        seen_pkt = t.packet_count;
        if (sample_cnt != 16'hFFFF) sample_cnt++;
        lring[ring_wr] = t.left_delta;
        rring[ring_wr] = t.right_delta;
        if (move_ms[0][31] && t.left_delta != 0) move_ms[0] = dt;
        if (move_ms[1][31] && t.right_delta != 0) move_ms[1] = dt;
        ring_wr = (ring_wr + 1) % RING_DEPTH;
        if (ring_cnt < RING_DEPTH) ring_cnt++;
      end
      if (el >= act_ms) begin
        drv_end[0] = t.left_total; drv_end[1] = t.right_total;
        mode_t0 = t.now_ms; seq_mode = MD_POST;
        w[0] = plain_word(EV_NONE, 0, 0);
      end else w[0] = plain_word(EV_NONE, 0, drive_rom(p));
    end else begin
      if (el >= settle_ms) begin
        nxt = p + 4'd1;
        nd = (nxt < PHASE_COUNT) ? drive_rom(nxt) : 14'd0;
        for (int k = 0; k < 2; k++) begin
          w[k] = plain_word(EV_RESULT, p + 4'd1, nd);
          w[k].wheel = k[0];
          w[k].sample_total = sample_cnt;
          w[k].driven_counts = drv_end[k] - drv_start[k];
          w[k].steady_mean = ring_avg(k[0]);
          w[k].coast_counts = (k == 0 ? t.left_total : t.right_total) - drv_end[k];
          w[k].first_move_ms = move_ms[k];
        end
        w[2] = (nxt < PHASE_COUNT) ? plain_word(EV_PHASE, nxt + 4'd1, nd)
                                   : plain_word(EV_DONE, 0, 0);
        n = 3;
        phase_idx = nxt;
        if (nxt < PHASE_COUNT) arm_phase(t);
        else seq_mode = MD_IDLE;
      end else w[0] = plain_word(EV_NONE, 0, 0);
    end
    w[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) expected_words.push_back(w[k]);
  endfunction

  // Driver: present the next queued tick, hold it until accepted.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) predict_tick(in_data);
      if (!in_valid || in_ready) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_data <= tick_q.pop_front();
          in_valid <= 1'b1;
        end else in_valid <= 1'b0;
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: compare each taken word with the oldest prediction.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word %p", out_data);
        errors++;
      end else begin
        out_word_t e;
        e = expected_words.pop_front();
        if (out_data.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, out_data.last); errors++;
        end
        if (out_data.event_res !== e.event_res) begin
          $error("event_res exp %0d got %0d", e.event_res, out_data.event_res);
          errors++;
        end
        if (out_data.phase_number !== e.phase_number) begin
          $error("phase_number exp %0d got %0d", e.phase_number, out_data.phase_number);
          errors++;
        end
        if (out_data.left_drive !== e.left_drive) begin
          $error("left_drive exp %0d got %0d", e.left_drive, out_data.left_drive);
          errors++;
        end
        if (out_data.right_drive !== e.right_drive) begin
          $error("right_drive exp %0d got %0d", e.right_drive, out_data.right_drive);
          errors++;
        end
        if (out_data.wheel !== e.wheel) begin
          $error("wheel exp %0d got %0d", e.wheel, out_data.wheel); errors++;
        end
        if (out_data.sample_total !== e.sample_total) begin
          $error("sample_total exp %0d got %0d", e.sample_total, out_data.sample_total);
          errors++;
        end
        if (out_data.driven_counts !== e.driven_counts) begin
          $error("driven_counts exp %0d got %0d", e.driven_counts, out_data.driven_counts);
          errors++;
        end
        if (out_data.steady_mean !== e.steady_mean) begin
          $error("steady_mean exp %0d got %0d", e.steady_mean, out_data.steady_mean);
          errors++;
        end
        if (out_data.coast_counts !== e.coast_counts) begin
          $error("coast_counts exp %0d got %0d", e.coast_counts, out_data.coast_counts);
          errors++;
        end
        if (out_data.first_move_ms !== e.first_move_ms) begin
          $error("first_move_ms exp %0d got %0d", e.first_move_ms, out_data.first_move_ms);
          errors++;
        end
      end
    end
    if (cycles > 400000 && !stim_done) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Stimulus clock, kept by the generator: time, encoder counter and totals.
  logic [31:0] clk_ms, pkt_n, ltot, rtot;

  function automatic in_word_t make_tick(logic [1:0] f, logic [31:0] step, bit stale, bit newpkt);
    in_word_t t;
    logic signed [15:0] dl, dr;
    clk_ms = clk_ms + step;
    // Mix small deltas with full-range ones so both extremes are seen.
    dl = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(20)) - 16'sd5;
    dr = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(20)) - 16'sd5;
    if ($urandom_range(5) == 0) dl = 0;
    if ($urandom_range(5) == 0) dr = 0;
    if (newpkt) begin
      pkt_n = pkt_n + 1 + ($urandom_range(7) == 0 ? $urandom : 0);
      if (pkt_n == 0) pkt_n = 1;
      ltot = ltot + 32'(dl); rtot = rtot + 32'(dr);
    end
    t.func = f;
    t.now_ms = clk_ms;
    t.packet_count = pkt_n;
    t.packet_time_ms = stale ? clk_ms - 32'd70000 - $urandom_range(1000)
                             : clk_ms - $urandom_range(3);
    t.left_total = ($urandom_range(15) == 0) ? $urandom : ltot;
    t.right_total = ($urandom_range(15) == 0) ? $urandom : rtot;
    t.left_delta = dl;
    t.right_delta = dr;
    return t;
  endfunction

  task automatic wait_drained();
    while (tick_q.size() != 0 || in_valid || expected_words.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_ACTIVE) act_ms = val;
    else if (idx == REG_SETTLE) settle_ms = val;
    else stale_ms = val;
  endtask

  // One run: start, then random ticks, with rare noise.
  task automatic queue_run(int steps, int maxstep);
    tick_q.push_back(make_tick(FUNC_START, 1, 0, 1));
    for (int i = 0; i < steps; i++) begin
      int r;
      r = $urandom_range(99);
      if (r < 1) tick_q.push_back(make_tick(FUNC_STOP, 1, 0, 0));
      else if (r < 2) tick_q.push_back(make_tick(FUNC_RUN, 1, 1, 0));
      else if (r < 4) tick_q.push_back(make_tick(FUNC_START, 1, 0, 1));
      else if (r < 6) tick_q.push_back(make_tick(FUNC_SPARE, $urandom_range(maxstep), 0, 1));
      else tick_q.push_back(make_tick(FUNC_RUN, $urandom_range(1, maxstep), 0,
                                      $urandom_range(3) != 0));
    end
  endtask

  initial begin
    clk_ms = 32'hFFFF_FF00; pkt_n = 0; ltot = 32'h7FFF_FFF0; rtot = 32'h8000_0010;
    reset_model();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: idle stop, start with stale and zero counter, start while
    // running, stop abort, unused func code entering a phase, stale abort.
    tick_q.push_back(make_tick(FUNC_STOP, 1, 0, 0));
    tick_q.push_back(make_tick(FUNC_START, 1, 0, 0));
    tick_q.push_back(make_tick(FUNC_RUN, 1, 0, 1));
    tick_q.push_back(make_tick(FUNC_START, 1, 1, 0));
    tick_q.push_back(make_tick(FUNC_START, 1, 0, 0));
    tick_q.push_back(make_tick(FUNC_START, 1, 0, 0));
    tick_q.push_back(make_tick(FUNC_STOP, 1, 0, 0));
    tick_q.push_back(make_tick(FUNC_START, 1, 0, 1));
    tick_q.push_back(make_tick(FUNC_SPARE, 900, 0, 1));
    tick_q.push_back(make_tick(FUNC_RUN, 1, 1, 0));
    wait_drained();
    write_reg(REG_ACTIVE, 16'd1);
    write_reg(REG_SETTLE, 16'd1);
    write_reg(REG_STALE, 16'd0);
    // Late first move: pre-settle then a huge jump in time during drive.
    clk_ms = 32'h1000;
    tick_q.push_back(make_tick(FUNC_START, 0, 0, 1));
    tick_q.push_back(make_tick(FUNC_RUN, 1, 0, 1));
    tick_q.push_back(make_tick(FUNC_RUN, 32'h9000_0000, 0, 1));
    tick_q.push_back(make_tick(FUNC_RUN, 1, 0, 1));
    tick_q.push_back(make_tick(FUNC_STOP, 1, 0, 0));
    wait_drained();

    // Random runs across settings and idling phases.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1 || ph == 3) ? 84 : 0;
      stall_pct = (ph == 2) ? 84 : (ph == 3 ? 16 : 0);
      if (ph == 3) idle_pct = 16;
      write_reg(REG_ACTIVE, ph == 0 ? 16'd2 : 16'($urandom_range(1, 4)));
      write_reg(REG_SETTLE, ph == 2 ? 16'd1 : 16'($urandom_range(1, 3)));
      write_reg(REG_STALE, ph == 3 ? 16'hFFFF : 16'($urandom_range(3, 5)));
      queue_run(60, 2);
      wait_drained();
    end
    // Large register values, with ticks jumping far in time.
    write_reg(REG_ACTIVE, 16'hFFFF);
    write_reg(REG_SETTLE, 16'hFFFF);
    write_reg(REG_STALE, 16'hFFFF);
    idle_pct = 0; stall_pct = 0;
    queue_run(20, 40000);
    while (tick_q.size() != 0 || in_valid) @(posedge clk);
    stim_done = 1'b1;
    for (int k = 0; k < 20000 && expected_words.size() != 0; k++) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
